### sv/shs_pkg.sv
`default_nettype none

package shs_pkg;

   typedef enum logic [2:0] {
      MODE_INACTIVE  = 3'd0,
      MODE_RECOVERY  = 3'd1,
      MODE_HOMING    = 3'd2,
      MODE_IDLE      = 3'd3,
      MODE_HIGH_LOAD = 3'd4,
      MODE_ACTIVE    = 3'd5
   } mode_type;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_START  = 2'd1;
   localparam logic [1:0] CMD_STOP   = 2'd2;
   localparam logic [1:0] CMD_TARGET = 2'd3;

   localparam logic [2:0] REG_FAULT_LINGER = 3'd0;
   localparam logic [2:0] REG_HOMING_MIN   = 3'd1;
   localparam logic [2:0] REG_HOMING_MAX   = 3'd2;
   localparam logic [2:0] REG_EARLY_OK     = 3'd3;
   localparam logic [2:0] REG_IDLE_SETTLE  = 3'd4;
   localparam logic [2:0] REG_POWER_ALERT  = 3'd5;
   localparam logic [2:0] REG_POWER_TRIP   = 3'd6;
   localparam logic [2:0] REG_TARGET_LIMIT = 3'd7;

   localparam logic [15:0] RST_FAULT_LINGER = 16'd500;
   localparam logic [15:0] RST_HOMING_MIN   = 16'd1000;
   localparam logic [15:0] RST_HOMING_MAX   = 16'd10000;
   localparam logic [7:0]  RST_EARLY_OK     = 8'd1;
   localparam logic [15:0] RST_IDLE_SETTLE  = 16'd200;
   localparam logic [15:0] RST_POWER_ALERT  = 16'd10000;
   localparam logic [15:0] RST_POWER_TRIP   = 16'd2000;
   localparam logic [15:0] RST_TARGET_LIMIT = 16'd65535;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] target_steps;
      logic [31:0] now_ms;
      logic        homing_status_ok;
      logic [15:0] power_mw;
      logic        overcurrent_fault;
   } req_type;

   typedef struct packed {
      logic        enable_drive;
      logic        direction_ccw;
      logic        step_pulse;
      logic [2:0]  state_code;
      logic [15:0] position_steps;
      logic        move_done;
      logic        home_valid;
   } rsp_type;

   typedef struct packed {
      logic [15:0] fault_linger_ms;
      logic [15:0] homing_min_ms;
      logic [15:0] homing_max_ms;
      logic [7:0]  early_ok_allowed;
      logic [15:0] idle_settle_ms;
      logic [15:0] power_alert_mw;
      logic [15:0] power_trip_ms;
      logic [15:0] target_limit_steps;
   } cfg_type;

   typedef struct packed {
      mode_type    current_state;
      mode_type    pending_state;
      logic        entry_pending;
      logic        drive_enabled;
      logic        enable_line;
      logic        direction_line;
      logic [7:0]  early_ok_count;
      logic [31:0] state_timer_ms;
      logic [15:0] position;
      logic [15:0] target;
   } sup_type;

endpackage

`default_nettype wire

### sv/shs_step.sv
`default_nettype none

module shs_step (
   input  shs_pkg::sup_type cur_state,
   input  shs_pkg::cfg_type cfg,
   input  shs_pkg::req_type req,
   output shs_pkg::sup_type nxt_state,
   output shs_pkg::rsp_type rsp
);
   import shs_pkg::*;

   sup_type     s;
   logic [31:0] elapsed;
   logic        stepped;

   always_comb begin
      s       = cur_state;
      stepped = 1'b0;
      elapsed = '0;
      case (req.cmd)
         CMD_TICK: begin
            if (s.entry_pending) begin
               case (s.current_state)
                  MODE_INACTIVE: begin
                     s.enable_line    = 1'b0;
                     s.direction_line = 1'b0;
                     s.drive_enabled  = 1'b0;
                  end
                  MODE_RECOVERY: begin
                     s.enable_line    = 1'b0;
                     s.direction_line = 1'b0;
                     s.drive_enabled  = 1'b0;
                     s.state_timer_ms = req.now_ms;
                  end
                  MODE_HOMING: begin
                     s.enable_line    = 1'b1;
                     s.early_ok_count = '0;
                     s.state_timer_ms = req.now_ms;
                  end
                  MODE_IDLE, MODE_HIGH_LOAD: begin
                     s.state_timer_ms = req.now_ms;
                  end
                  default: begin
                  end
               endcase
               s.entry_pending = 1'b0;
            end
            elapsed = req.now_ms - s.state_timer_ms;

            case (s.current_state)
               MODE_RECOVERY: begin
                  if (elapsed > {16'd0, cfg.fault_linger_ms}) s.pending_state = MODE_INACTIVE;
               end
               MODE_HOMING: begin
                  if (req.homing_status_ok) begin
                     if (elapsed < {16'd0, cfg.homing_min_ms}) begin
                        if (s.early_ok_count >= cfg.early_ok_allowed) begin
                           s.pending_state = MODE_RECOVERY;
                        end else begin
                           s.early_ok_count = s.early_ok_count + 8'd1;
                        end
                     end else begin
                        s.drive_enabled = 1'b1;
                        s.pending_state = MODE_IDLE;
                     end
                  end
                  if (elapsed > {16'd0, cfg.homing_max_ms}) s.pending_state = MODE_RECOVERY;
               end
               MODE_IDLE: begin
                  if (s.position != s.target) s.pending_state = MODE_ACTIVE;
                  if (elapsed > {16'd0, cfg.idle_settle_ms} && req.power_mw > cfg.power_alert_mw)
                     s.pending_state = MODE_HIGH_LOAD;
                  if (req.overcurrent_fault) s.pending_state = MODE_RECOVERY;
               end
               MODE_HIGH_LOAD: begin
                  if (s.position != s.target) s.pending_state = MODE_ACTIVE;
                  if (elapsed > {16'd0, cfg.power_trip_ms}) begin
                     s.pending_state = (req.power_mw > cfg.power_alert_mw) ? MODE_RECOVERY
                                                                          : MODE_IDLE;
                  end
                  if (req.overcurrent_fault) s.pending_state = MODE_RECOVERY;
               end
               MODE_ACTIVE: begin
                  if (s.position != s.target) begin
                     if (s.position < s.target) begin
                        s.direction_line = 1'b1;
                        s.position       = s.position + 16'd1;
                     end else begin
                        s.direction_line = 1'b0;
                        s.position       = s.position - 16'd1;
                     end
                     stepped = 1'b1;
                  end else begin
                     s.pending_state = MODE_IDLE;
                  end
                  if (req.overcurrent_fault) s.pending_state = MODE_RECOVERY;
               end
               default: begin
               end
            endcase

            if (s.pending_state != s.current_state) begin
               s.current_state = s.pending_state;
               s.entry_pending = 1'b1;
            end
         end
         CMD_START: begin
            if (s.drive_enabled || s.early_ok_count != 8'd0) begin
               s.enable_line   = 1'b0;
               s.drive_enabled = 1'b0;
            end
            s.pending_state = MODE_HOMING;
         end
         CMD_STOP: begin
            s.pending_state = MODE_RECOVERY;
         end
         CMD_TARGET: begin
            if (req.target_steps < cfg.target_limit_steps) s.target = req.target_steps;
         end
         default: begin
         end
      endcase
   end

   assign nxt_state = s;

   assign rsp.enable_drive   = s.enable_line;
   assign rsp.direction_ccw  = s.direction_line;
   assign rsp.step_pulse     = stepped;
   assign rsp.state_code     = s.current_state;
   assign rsp.position_steps = s.position;
   assign rsp.move_done      = (s.position == s.target);
   assign rsp.home_valid     = s.drive_enabled && (s.early_ok_count != 8'd0);

endmodule

`default_nettype wire

### sv/servo_homing_supervisor.sv
// supervisor for one step/direction servo: homing, idle, high load, active,
// error recovery and inactive, driven by a stream of commands
// request channel (req_valid/req_ready/req_data): one command per request,
// tick, start homing, stop or set target; a tick carries time, homing
// status, power and overcurrent
// response channel (rsp_valid/rsp_ready/rsp_data): exactly one response per
// request, in order: enable and direction lines, step pulse, state code,
// position, move done and home valid
// csr channel (csr_valid/csr_ready/csr_index/csr_wdata): writes one of the
// eight timing and limit registers; always ready, write only while idle
// path: a request is held in the input register, then one pass of the state
// update writes the response register
// throughput: one request per cycle unless the response side stalls; the state
// update is combinational, so each request sees the result of the previous one
// reset: registers return to defaults, state goes inactive, both holding
// stages empty
// stall: a response waits in its register while rsp_ready is low; one more
// request is held in the input register, then req_ready drops
`default_nettype none

module servo_homing_supervisor (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  shs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output shs_pkg::rsp_type rsp_data,
   input  wire              csr_valid,
   output logic             csr_ready,
   input  wire  [2:0]       csr_index,
   input  wire  [15:0]      csr_wdata
);
   import shs_pkg::*;

   logic    in_valid_ff;
   req_type in_req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   sup_type sup_ff;
   sup_type sup_in;
   rsp_type rsp_in;
   cfg_type cfg_ff;
   logic    advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   shs_step u_step (
      .cur_state (sup_ff),
      .cfg       (cfg_ff),
      .req       (in_req_ff),
      .nxt_state (sup_in),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sup_ff       <= '{current_state: MODE_INACTIVE, pending_state: MODE_INACTIVE,
                           default: '0};
         cfg_ff       <= '{fault_linger_ms:    RST_FAULT_LINGER,
                           homing_min_ms:      RST_HOMING_MIN,
                           homing_max_ms:      RST_HOMING_MAX,
                           early_ok_allowed:   RST_EARLY_OK,
                           idle_settle_ms:     RST_IDLE_SETTLE,
                           power_alert_mw:     RST_POWER_ALERT,
                           power_trip_ms:      RST_POWER_TRIP,
                           target_limit_steps: RST_TARGET_LIMIT};
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            sup_ff       <= sup_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FAULT_LINGER: cfg_ff.fault_linger_ms    <= csr_wdata;
               REG_HOMING_MIN:   cfg_ff.homing_min_ms      <= csr_wdata;
               REG_HOMING_MAX:   cfg_ff.homing_max_ms      <= csr_wdata;
               REG_EARLY_OK:     cfg_ff.early_ok_allowed   <= csr_wdata[7:0];
               REG_IDLE_SETTLE:  cfg_ff.idle_settle_ms     <= csr_wdata;
               REG_POWER_ALERT:  cfg_ff.power_alert_mw     <= csr_wdata;
               REG_POWER_TRIP:   cfg_ff.power_trip_ms      <= csr_wdata;
               REG_TARGET_LIMIT: cfg_ff.target_limit_steps <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_req_ff <= req_data;
      if (advance) rsp_data_ff <= rsp_in;
   end

endmodule

`default_nettype wire

### sv/shs_checker.sv
`default_nettype none

module shs_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_ready,
   input shs_pkg::req_type req_data,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input shs_pkg::rsp_type rsp_data,
   input wire              csr_valid,
   input wire              csr_ready,
   input wire  [2:0]       csr_index,
   input wire  [15:0]      csr_wdata
);
   import shs_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a step only happens in active; a pending start or stop, or an overcurrent,
   // can move the state on the same tick
   a_step_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.step_pulse |->
         rsp_data.state_code == MODE_ACTIVE || rsp_data.state_code == MODE_RECOVERY ||
         rsp_data.state_code == MODE_HOMING)
      else $error("step pulse outside active");

   // state code stays within the six modes
   a_state_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.state_code <= MODE_ACTIVE)
      else $error("state code out of range");

   // a request taken with no response held is answered via the input register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid ##1 !reset |=> rsp_valid)
      else $error("response missing after request");

endmodule

bind servo_homing_supervisor shs_checker u_shs_checker (.*);

`default_nettype wire

### test/servo_homing_supervisor_checker.sv
module servo_homing_supervisor_checker (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   input  wire              req_ready,
   input  shs_pkg::req_type req_data,
   input  wire              rsp_valid,
   input  wire              rsp_ready,
   input  shs_pkg::rsp_type rsp_data,
   input  wire              csr_valid,
   input  wire              csr_ready,
   input  wire  [2:0]       csr_index,
   input  wire  [15:0]      csr_wdata,
   output int               mismatches,
   output int               awaiting,
   output logic [5:0]       modes_seen,
   output int               steps_seen,
   output int               homed_seen
);
   import shs_pkg::*;

   cfg_type     limits;
   mode_type    cur_mode;
   mode_type    next_mode;
   logic        entry_due;
   logic        drive_on;
   logic        en_line;
   logic        dir_line;
   logic [7:0]  early_count;
   logic [31:0] mark_ms;
   logic [15:0] pos;
   logic [15:0] goal;
   rsp_type     status_due[$];
   int          responses;

   task automatic report_mismatch(input string msg);
      $display("mismatch at response %0d: %s", responses, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   function automatic rsp_type next_status(input req_type r);
      rsp_type     o;
      logic [31:0] elapsed;
      logic        stepped;
      stepped = 1'b0;
      case (r.cmd)
         CMD_TICK: begin
            // entry actions of the state chosen on the previous tick
            if (entry_due) begin
               case (cur_mode)
                  MODE_INACTIVE, MODE_RECOVERY: begin
                     en_line = 1'b0;
                     dir_line = 1'b0;
                     drive_on = 1'b0;
                     if (cur_mode == MODE_RECOVERY) mark_ms = r.now_ms;
                  end
                  MODE_HOMING: begin
                     en_line = 1'b1;
                     early_count = 8'd0;
                     mark_ms = r.now_ms;
                  end
                  MODE_IDLE, MODE_HIGH_LOAD: mark_ms = r.now_ms;
                  default: ;
               endcase
               entry_due = 1'b0;
            end
            elapsed = r.now_ms - mark_ms;
            // later rules override earlier ones
            case (cur_mode)
               MODE_RECOVERY: begin
                  if (elapsed > limits.fault_linger_ms) next_mode = MODE_INACTIVE;
               end
               MODE_HOMING: begin
                  if (r.homing_status_ok) begin
                     if (elapsed < limits.homing_min_ms) begin
                        if (early_count >= limits.early_ok_allowed) begin
                           next_mode = MODE_RECOVERY;
                        end else begin
                           early_count = early_count + 8'd1;
                        end
                     end else begin
                        drive_on = 1'b1;
                        next_mode = MODE_IDLE;
                     end
                  end
                  if (elapsed > limits.homing_max_ms) next_mode = MODE_RECOVERY;
               end
               MODE_IDLE: begin
                  if (pos != goal) next_mode = MODE_ACTIVE;
                  if (elapsed > limits.idle_settle_ms && r.power_mw > limits.power_alert_mw) begin
                     next_mode = MODE_HIGH_LOAD;
                  end
                  if (r.overcurrent_fault) next_mode = MODE_RECOVERY;
               end
               MODE_HIGH_LOAD: begin
                  if (pos != goal) next_mode = MODE_ACTIVE;
                  if (elapsed > limits.power_trip_ms) begin
                     if (r.power_mw > limits.power_alert_mw) begin
                        next_mode = MODE_RECOVERY;
                     end else begin
                        next_mode = MODE_IDLE;
                     end
                  end
                  if (r.overcurrent_fault) next_mode = MODE_RECOVERY;
               end
               MODE_ACTIVE: begin
                  if (pos != goal) begin
                     dir_line = (pos < goal);
                     if (pos < goal) begin
                        pos = pos + 16'd1;
                     end else begin
                        pos = pos - 16'd1;
                     end
                     stepped = 1'b1;
                  end else begin
                     next_mode = MODE_IDLE;
                  end
                  if (r.overcurrent_fault) next_mode = MODE_RECOVERY;
               end
               default: ;
            endcase
            if (next_mode != cur_mode) begin
               cur_mode = next_mode;
               entry_due = 1'b1;
            end
         end
         CMD_START: begin
            if (drive_on || early_count != 8'd0) begin
               en_line = 1'b0;
               drive_on = 1'b0;
            end
            next_mode = MODE_HOMING;
         end
         CMD_STOP: next_mode = MODE_RECOVERY;
         CMD_TARGET: begin
            if (r.target_steps < limits.target_limit_steps) goal = r.target_steps;
         end
         default: ;
      endcase
      o.enable_drive = en_line;
      o.direction_ccw = dir_line;
      o.step_pulse = stepped;
      o.state_code = cur_mode;
      o.position_steps = pos;
      o.move_done = (pos == goal);
      o.home_valid = drive_on && (early_count != 8'd0);
      return o;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         limits.fault_linger_ms = RST_FAULT_LINGER;
         limits.homing_min_ms = RST_HOMING_MIN;
         limits.homing_max_ms = RST_HOMING_MAX;
         limits.early_ok_allowed = RST_EARLY_OK;
         limits.idle_settle_ms = RST_IDLE_SETTLE;
         limits.power_alert_mw = RST_POWER_ALERT;
         limits.power_trip_ms = RST_POWER_TRIP;
         limits.target_limit_steps = RST_TARGET_LIMIT;
         cur_mode = MODE_INACTIVE;
         next_mode = MODE_INACTIVE;
         entry_due = 1'b0;
         drive_on = 1'b0;
         en_line = 1'b0;
         dir_line = 1'b0;
         early_count = 8'd0;
         mark_ms = 32'd0;
         pos = 16'd0;
         goal = 16'd0;
         status_due.delete();
         responses = 0;
         mismatches = 0;
         modes_seen = 6'd0;
         steps_seen = 0;
         homed_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FAULT_LINGER: limits.fault_linger_ms = csr_wdata;
               REG_HOMING_MIN:   limits.homing_min_ms = csr_wdata;
               REG_HOMING_MAX:   limits.homing_max_ms = csr_wdata;
               REG_EARLY_OK:     limits.early_ok_allowed = csr_wdata[7:0];
               REG_IDLE_SETTLE:  limits.idle_settle_ms = csr_wdata;
               REG_POWER_ALERT:  limits.power_alert_mw = csr_wdata;
               REG_POWER_TRIP:   limits.power_trip_ms = csr_wdata;
               REG_TARGET_LIMIT: limits.target_limit_steps = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            want = next_status(req_data);
            status_due.push_back(want);
            modes_seen[cur_mode] = 1'b1;
            steps_seen += want.step_pulse;
            homed_seen += want.home_valid;
         end
         if (rsp_valid && rsp_ready) begin
            responses++;
            got = rsp_data;
            if (status_due.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = status_due.pop_front();
               compare_field("enable_drive", got.enable_drive, want.enable_drive);
               compare_field("direction_ccw", got.direction_ccw, want.direction_ccw);
               compare_field("step_pulse", got.step_pulse, want.step_pulse);
               compare_field("state_code", got.state_code, want.state_code);
               compare_field("position_steps", got.position_steps, want.position_steps);
               compare_field("move_done", got.move_done, want.move_done);
               compare_field("home_valid", got.home_valid, want.home_valid);
            end
         end
      end
      awaiting = status_due.size();
   end

endmodule

### test/servo_homing_supervisor_tb.sv
module servo_homing_supervisor_tb;
   import shs_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 9;
   localparam int PHASE_REQUESTS = 42;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   int          mismatches;
   int          awaiting;
   logic [5:0]  modes_seen;
   int          steps_seen;
   int          homed_seen;

   int          cycles = 0;
   int          sent = 0;
   int          hold_requests = 0;
   int          holds_served = 0;
   bit          no_idle = 1'b0;
   logic [31:0] now_ms;
   logic [15:0] alert_mw;
   int          dt_max;

   servo_homing_supervisor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   servo_homing_supervisor_checker check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .awaiting   (awaiting),
      .modes_seen (modes_seen),
      .steps_seen (steps_seen),
      .homed_seen (homed_seen)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles, awaiting);
         $display("FAILURE");
         $finish;
      end
   end

   // response side: random stalls, plus long hold-offs on demand
   initial begin : receiver
      int held;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            rsp_ready <= 1'b0;
            for (held = 0; held < 64; held++) @(negedge clock);
            holds_served++;
         end else if (!no_idle && $urandom_range(99) < 27) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input req_type item);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic tick(input int unsigned dt, input logic ok, input logic [15:0] pwr,
                       input logic oc);
      req_type item;
      now_ms = now_ms + dt;
      item.cmd = CMD_TICK;
      item.target_steps = 16'($urandom);
      item.now_ms = now_ms;
      item.homing_status_ok = ok;
      item.power_mw = pwr;
      item.overcurrent_fault = oc;
      send_request(item);
   endtask

   task automatic command(input logic [1:0] cmd, input logic [15:0] tgt);
      req_type item;
      item.cmd = cmd;
      item.target_steps = tgt;
      item.now_ms = $urandom;
      item.homing_status_ok = 1'($urandom);
      item.power_mw = 16'($urandom);
      item.overcurrent_fault = 1'($urandom);
      send_request(item);
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaiting != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_power(input bit high);
      if (high && alert_mw != 16'hFFFF) begin
         return 16'($urandom_range(32'hFFFF, 32'(alert_mw) + 1));
      end
      return 16'($urandom_range(32'(alert_mw), 0));
   endfunction

   initial begin : stimulus
      req_type noise;
      cfg_type limits;
      int      phase;
      int      phase_start;
      int      len;
      int      i;
      int      pick;
      bit      mid_done;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = REG_FAULT_LINGER;
      csr_wdata = 16'd0;
      now_ms = 32'hFFFF_FC00;
      alert_mw = RST_POWER_ALERT;
      dt_max = int'(RST_HOMING_MIN) / 3 + 10;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            drain();
            if (phase == 1) begin
               limits = '0;
            end else if (phase == 2) begin
               limits = '1;
            end else begin
               limits.fault_linger_ms = 16'($urandom_range(300));
               limits.homing_min_ms = 16'($urandom_range(200));
               if ($urandom_range(99) < 15) begin
                  limits.homing_max_ms = 16'($urandom_range(100));
               end else begin
                  limits.homing_max_ms = limits.homing_min_ms + 16'($urandom_range(400));
               end
               limits.early_ok_allowed = 8'($urandom_range(3));
               limits.idle_settle_ms = 16'($urandom_range(200));
               limits.power_alert_mw = 16'($urandom);
               limits.power_trip_ms = 16'($urandom_range(300));
               if ($urandom_range(1) == 0) begin
                  limits.target_limit_steps = 16'hFFFF;
               end else begin
                  limits.target_limit_steps = 16'($urandom_range(65535, 8));
               end
            end
            write_register(REG_FAULT_LINGER, limits.fault_linger_ms);
            write_register(REG_HOMING_MIN, limits.homing_min_ms);
            write_register(REG_HOMING_MAX, limits.homing_max_ms);
            // upper byte is don't-care for the allowance
            write_register(REG_EARLY_OK, {(phase == 1) ? 8'h00 : 8'($urandom),
                                          limits.early_ok_allowed});
            write_register(REG_IDLE_SETTLE, limits.idle_settle_ms);
            write_register(REG_POWER_ALERT, limits.power_alert_mw);
            write_register(REG_POWER_TRIP, limits.power_trip_ms);
            write_register(REG_TARGET_LIMIT, limits.target_limit_steps);
            alert_mw = limits.power_alert_mw;
            dt_max = int'(limits.homing_min_ms) / 3 + 10;
         end
         no_idle = (phase == 3);
         mid_done = 1'b0;
         phase_start = sent;

         if (phase == 0) begin
            // inactive ignores a tick, target at the limit is dropped
            tick(0, 1'b1, 16'hFFFF, 1'b1);
            command(CMD_TARGET, 16'hFFFF);
            // early ok, start while homing, then too many early oks
            command(CMD_START, 16'($urandom));
            tick(7, 1'b0, 16'd0, 1'b0);
            tick(5, 1'b1, 16'd0, 1'b0);
            command(CMD_START, 16'($urandom));
            tick(400, 1'b1, 16'd0, 1'b0);
            tick(10, 1'b0, 16'd0, 1'b0);
            tick(600, 1'b0, 16'd0, 1'b0);
            // homing with one early ok, then home valid
            command(CMD_START, 16'($urandom));
            tick(3, 1'b0, 16'd0, 1'b0);
            tick(3, 1'b1, 16'd0, 1'b0);
            tick(1200, 1'b1, 16'h1234, 1'b0);
            tick(1, 1'b0, 16'd0, 1'b0);
            // move up three steps and settle
            command(CMD_TARGET, 16'd3);
            repeat (5) tick(1, 1'b0, 16'd0, 1'b0);
            // idle to high load and back
            tick(1, 1'b0, 16'd0, 1'b0);
            tick(300, 1'b0, 16'hFFFF, 1'b0);
            tick(1, 1'b0, 16'hFFFF, 1'b0);
            tick(2100, 1'b0, 16'd0, 1'b0);
            // step down with overcurrent
            command(CMD_TARGET, 16'd0);
            tick(1, 1'b0, 16'd0, 1'b0);
            tick(1, 1'b0, 16'd0, 1'b1);
         end

         while (sent - phase_start < PHASE_REQUESTS + ((phase == 0) ? 25 : 0)) begin
            if (!mid_done && sent - phase_start > 12) begin
               if (phase == 4) hold_requests++;
               if (phase == 5) drain();
               mid_done = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 30) begin
               command(CMD_START, 16'($urandom));
               len = $urandom_range(12, 3);
               for (i = 0; i < len; i++) begin
                  tick($urandom_range(dt_max), $urandom_range(99) < 6 * i, pick_power(0),
                       $urandom_range(99) < 3);
               end
            end else if (pick < 55) begin
               if ($urandom_range(9) == 0) begin
                  command(CMD_TARGET, 16'($urandom));
               end else begin
                  command(CMD_TARGET, 16'($urandom_range(40)));
               end
               repeat ($urandom_range(15, 2)) begin
                  tick($urandom_range(dt_max), 1'($urandom), pick_power($urandom_range(99) < 15),
                       $urandom_range(99) < 3);
               end
            end else if (pick < 70) begin
               repeat ($urandom_range(12, 3)) begin
                  tick($urandom_range(dt_max), 1'($urandom), pick_power($urandom_range(99) < 70),
                       $urandom_range(99) < 3);
               end
            end else if (pick < 80) begin
               command(CMD_STOP, 16'($urandom));
               repeat ($urandom_range(6, 1)) begin
                  tick($urandom_range(dt_max), 1'($urandom), pick_power(0), 1'b0);
               end
            end else begin
               noise.cmd = 2'($urandom);
               noise.target_steps = 16'($urandom);
               noise.now_ms = $urandom;
               noise.homing_status_ok = 1'($urandom);
               noise.power_mw = 16'($urandom);
               noise.overcurrent_fault = 1'($urandom);
               send_request(noise);
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("%0d requests over %0d register settings, defaults and both extremes included",
               sent, PHASES);
      $display("modes reached %b, %0d step pulses, home valid on %0d responses",
               modes_seen, steps_seen, homed_seen);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
